/* rtl/jmwv_pkg.sv */
`timescale 1ns / 1ps

package jmwv_pkg;

    localparam int STOP_BITS = 32;

    localparam logic [7:0] BYTE_FF     = 8'hFF;
    localparam logic [7:0] BYTE_SOI    = 8'hD8;
    localparam logic [7:0] BYTE_EOI    = 8'hD9;
    localparam logic [7:0] BYTE_SOS    = 8'hDA;
    localparam logic [7:0] BYTE_STUFF  = 8'h00;
    localparam logic [7:0] BYTE_RST_LO = 8'hD0;
    localparam logic [7:0] BYTE_RST_HI = 8'hD7;

    localparam logic [1:0] VERDICT_INVALID   = 2'd0;
    localparam logic [1:0] VERDICT_PROMISING = 2'd1;
    localparam logic [1:0] VERDICT_VALID     = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           verdict;
        logic [STOP_BITS-1:0] stop_position;
    } t_walk_res;

endpackage

/* rtl/jmwv_in_reg.sv */
`timescale 1ns / 1ps

module jmwv_in_reg
    import jmwv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;
    assign o_last_byte = r_last;

endmodule

/* rtl/jmwv_walk.sv */
`timescale 1ns / 1ps

module jmwv_walk
    import jmwv_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_walk_res  o_res
);

    localparam int PB = POSITION_BITS;
    localparam int PW = POSITION_BITS + 1;

    localparam logic [3:0] PH_HDR0  = 4'd0;
    localparam logic [3:0] PH_HDR1  = 4'd1;
    localparam logic [3:0] PH_SCAN  = 4'd2;
    localparam logic [3:0] PH_MARK  = 4'd3;
    localparam logic [3:0] PH_LENHI = 4'd4;
    localparam logic [3:0] PH_LENLO = 4'd5;
    localparam logic [3:0] PH_SKIP  = 4'd6;
    localparam logic [3:0] PH_BAD   = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;

    logic [3:0]    r_phase,   n_phase;
    logic [PB-1:0] r_pos,     n_pos;
    logic [15:0]   r_skip,    n_skip;
    logic [PB-1:0] r_mark,    n_mark;
    logic [PB-1:0] r_mark_p2, n_mark_p2;
    logic [7:0]    r_len_hi,  n_len_hi;
    logic          r_scan,    n_scan;
    logic          r_given,   n_given;

    logic [PW-1:0] w_pos_inc;
    logic [PW-1:0] w_pos_p2;
    logic [PW-1:0] w_mark_len;
    logic [PW-1:0] w_skip_end;
    logic [15:0]   w_held;
    logic [15:0]   w_held_m2;
    logic [PB-1:0] w_end;
    logic [1:0]    w_verdict;
    logic          w_res_valid;
    logic [STOP_BITS-1:0] w_stop;

    assign w_held     = {r_len_hi, i_data_byte};
    assign w_held_m2  = w_held - 16'd2;
    assign w_pos_inc  = {1'b0, r_pos} + PW'(1);
    assign w_pos_p2   = {1'b0, r_pos} + PW'(2);
    assign w_mark_len = {1'b0, r_mark_p2} + PW'(w_held);
    assign w_skip_end = {1'b0, r_pos} + PW'(r_skip);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_mark      = r_mark;
        n_mark_p2   = r_mark_p2;
        n_len_hi    = r_len_hi;
        n_scan      = r_scan;
        n_given     = r_given;
        w_end       = r_pos;
        w_verdict   = VERDICT_INVALID;
        w_res_valid = 1'b0;

        if (!r_given) begin
            case (r_phase)
                PH_HDR0: begin
                    n_phase = (i_data_byte == BYTE_FF) ? PH_HDR1 : PH_BAD;
                end
                PH_HDR1: begin
                    n_phase = (i_data_byte == BYTE_SOI) ? PH_SCAN : PH_BAD;
                end
                PH_SCAN: begin
                    if (i_data_byte == BYTE_FF) begin
                        n_mark    = r_pos;
                        n_mark_p2 = w_pos_p2[PB] ? '1 : w_pos_p2[PB-1:0];
                        n_phase   = PH_MARK;
                    end
                end
                PH_MARK: begin
                    if (i_data_byte == BYTE_STUFF ||
                        (i_data_byte >= BYTE_RST_LO && i_data_byte <= BYTE_RST_HI)) begin
                        w_end   = r_mark_p2;
                        n_phase = PH_SCAN;
                    end else if (i_data_byte == BYTE_EOI) begin
                        w_end       = r_mark_p2;
                        w_verdict   = VERDICT_VALID;
                        w_res_valid = 1'b1;
                        n_given     = 1'b1;
                        n_phase     = PH_DONE;
                    end else if (i_data_byte == BYTE_SOS) begin
                        w_end   = r_mark_p2;
                        n_scan  = 1'b1;
                        n_phase = PH_SCAN;
                    end else begin
                        w_end   = r_mark;
                        n_phase = PH_LENHI;
                    end
                end
                PH_LENHI: begin
                    n_len_hi = i_data_byte;
                    w_end    = r_mark;
                    n_phase  = PH_LENLO;
                end
                PH_LENLO: begin
                    if (w_held < 16'd2) begin
                        n_phase = PH_SCAN;
                    end else begin
                        w_end   = w_mark_len[PB] ? '1 : w_mark_len[PB-1:0];
                        n_skip  = w_held_m2;
                        n_phase = (w_held_m2 != 16'd0) ? PH_SKIP : PH_SCAN;
                    end
                end
                PH_SKIP: begin
                    w_end = w_skip_end[PB] ? '1 : w_skip_end[PB-1:0];
                    if (r_skip != 16'd0) begin
                        n_skip = r_skip - 16'd1;
                    end
                    if (r_skip <= 16'd1) begin
                        n_phase = PH_SCAN;
                    end
                end
                default: begin
                end
            endcase

            if (!w_res_valid && i_last_byte) begin
                w_res_valid = 1'b1;
                if (n_phase == PH_BAD || n_phase == PH_HDR0 || n_phase == PH_HDR1 ||
                    r_pos < PB'(3)) begin
                    w_verdict = VERDICT_INVALID;
                    w_end     = '0;
                end else begin
                    w_verdict = n_scan ? VERDICT_PROMISING : VERDICT_INVALID;
                end
            end
        end

        if (i_last_byte) begin
            n_phase   = PH_HDR0;
            n_pos     = '0;
            n_skip    = '0;
            n_mark    = '0;
            n_mark_p2 = '0;
            n_len_hi  = '0;
            n_scan    = 1'b0;
            n_given   = 1'b0;
        end else begin
            n_pos = w_pos_inc[PB] ? '1 : w_pos_inc[PB-1:0];
        end
    end

    generate
        if (PB > STOP_BITS) begin : g_wide
            assign w_stop = (|w_end[PB-1:STOP_BITS]) ? '1 : w_end[STOP_BITS-1:0];
        end else begin : g_narrow
            assign w_stop = STOP_BITS'(w_end);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_pos     <= '0;
            r_skip    <= '0;
            r_mark    <= '0;
            r_mark_p2 <= '0;
            r_len_hi  <= '0;
            r_scan    <= 1'b0;
            r_given   <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_mark    <= n_mark;
            r_mark_p2 <= n_mark_p2;
            r_len_hi  <= n_len_hi;
            r_scan    <= n_scan;
            r_given   <= n_given;
        end
    end

    assign o_res.valid         = w_res_valid;
    assign o_res.verdict       = w_verdict;
    assign o_res.stop_position = w_stop;

endmodule

/* rtl/jpeg_marker_walk_validator.sv */
// A byte that produces a verdict waits in the input register until the walk takes it, and the result
// register loads its verdict at the edge on which the byte is taken.
// Throughput: one byte per cycle while a held result does not stall the output; the walk state updates
// once per byte in a single pass. Reset is synchronous and active low; it clears the walk state and both
// valid flags. A byte flagged as last also returns the walk to its initial state for the next file.
`timescale 1ns / 1ps

module jpeg_marker_walk_validator
    import jmwv_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_stop_position
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_in_last;
    logic       w_proc;
    t_walk_res  w_res;

    logic                 r_out_valid;
    logic [1:0]           r_out_verdict;
    logic [STOP_BITS-1:0] r_out_pos;

    assign w_proc = w_in_valid && (!r_out_valid || !i_stall);

    jmwv_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_take      (w_proc),
        .o_stall     (o_stall),
        .o_valid     (w_in_valid),
        .o_data_byte (w_in_byte),
        .o_last_byte (w_in_last)
    );

    jmwv_walk #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_proc),
        .i_data_byte (w_in_byte),
        .i_last_byte (w_in_last),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= w_res.valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res.valid) begin
            r_out_verdict <= w_res.verdict;
            r_out_pos     <= w_res.stop_position;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_verdict       = r_out_verdict;
    assign o_stop_position = r_out_pos;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_valid |-> !o_stall)
        else $error("input stalled with an empty input register");

    a_hold_blocks_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_proc)
        else $error("walk advanced while a result was held");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_stall && !w_proc) |=> !r_out_valid)
        else $error("result repeated after its transfer");

    a_valid_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict == VERDICT_VALID) |-> (r_out_pos >= 32'd4))
        else $error("end-of-image verdict with an impossible position");

endmodule

/* tb/jpeg_marker_walk_validator_tb.sv */
`timescale 1ns / 1ps

module jpeg_marker_walk_validator_tb;
    import jmwv_pkg::*;

    localparam logic [7:0]  MARK_APP0    = 8'hE0;
    localparam logic [7:0]  MARK_APP1    = 8'hE1;
    localparam logic [7:0]  MARK_DHT     = 8'hC4;
    localparam logic [63:0] POS_MAX      = 64'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES = 8;

    typedef enum logic [3:0] {
        WALK_HDR0,
        WALK_HDR1,
        WALK_SCAN,
        WALK_MARK,
        WALK_LEN_HI,
        WALK_LEN_LO,
        WALK_SKIP,
        WALK_BAD,
        WALK_DONE
    } t_walk_phase;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] stop_position;
    } t_verdict_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_verdict;
    logic [31:0] o_stop_position;

    t_walk_phase  walk_phase = WALK_HDR0;
    logic [63:0]  walk_pos = '0;
    logic [16:0]  walk_skip = '0;
    logic [63:0]  walk_marker = '0;
    logic [7:0]   walk_len_hi = '0;
    logic [15:0]  walk_held = '0;
    logic         walk_scan_seen = 1'b0;
    logic         walk_verdict_given = 1'b0;

    t_verdict_rec pending_verdicts[$];
    logic [7:0]   file_bytes[$];
    int           error_count = 0;
    int           bytes_sent = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_len = 0;
    int           hold_trigger = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    jpeg_marker_walk_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_verdict       (o_verdict),
        .o_stop_position (o_stop_position)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] pos_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] sum;
        sum = a + b;
        return (sum > POS_MAX) ? POS_MAX : sum;
    endfunction

    function automatic void clear_walk();
        walk_phase         = WALK_HDR0;
        walk_pos           = '0;
        walk_skip          = '0;
        walk_marker        = '0;
        walk_len_hi        = '0;
        walk_held          = '0;
        walk_scan_seen     = 1'b0;
        walk_verdict_given = 1'b0;
    endfunction

    function automatic logic walk_step(input logic [7:0] b, input logic is_last,
                                       output t_verdict_rec rec);
        logic [63:0] idx;
        logic [63:0] endpos;
        logic [1:0]  verdict;
        logic        emit;
        idx     = walk_pos;
        endpos  = idx;
        verdict = VERDICT_INVALID;
        emit    = 1'b0;
        if (!walk_verdict_given) begin
            case (walk_phase)
                WALK_HDR0: begin
                    walk_phase = (b == BYTE_FF) ? WALK_HDR1 : WALK_BAD;
                end
                WALK_HDR1: begin
                    walk_phase = (b == BYTE_SOI) ? WALK_SCAN : WALK_BAD;
                end
                WALK_SCAN: begin
                    if (b == BYTE_FF) begin
                        walk_marker = idx;
                        walk_phase  = WALK_MARK;
                    end
                end
                WALK_MARK: begin
                    if (b == BYTE_STUFF || (b >= BYTE_RST_LO && b <= BYTE_RST_HI)) begin
                        endpos     = pos_add(walk_marker, 64'd2);
                        walk_phase = WALK_SCAN;
                    end else if (b == BYTE_EOI) begin
                        verdict            = VERDICT_VALID;
                        endpos             = pos_add(walk_marker, 64'd2);
                        walk_verdict_given = 1'b1;
                        walk_phase         = WALK_DONE;
                        emit               = 1'b1;
                    end else if (b == BYTE_SOS) begin
                        walk_scan_seen = 1'b1;
                        endpos         = pos_add(walk_marker, 64'd2);
                        walk_phase     = WALK_SCAN;
                    end else begin
                        endpos     = walk_marker;
                        walk_phase = WALK_LEN_HI;
                    end
                end
                WALK_LEN_HI: begin
                    walk_len_hi = b;
                    endpos      = walk_marker;
                    walk_phase  = WALK_LEN_LO;
                end
                WALK_LEN_LO: begin
                    walk_held = {walk_len_hi, b};
                    if (walk_held < 16'd2) begin
                        endpos     = idx;
                        walk_phase = WALK_SCAN;
                    end else begin
                        endpos     = pos_add(pos_add(walk_marker, 64'd2), 64'(walk_held));
                        walk_skip  = 17'(walk_held) - 17'd2;
                        walk_phase = (walk_skip != 0) ? WALK_SKIP : WALK_SCAN;
                    end
                end
                WALK_SKIP: begin
                    endpos = pos_add(idx, 64'(walk_skip));
                    if (walk_skip != 0) walk_skip = walk_skip - 17'd1;
                    if (walk_skip == 0) walk_phase = WALK_SCAN;
                end
                default: begin
                end
            endcase
            if (!emit && is_last) begin
                if (walk_phase == WALK_BAD || walk_phase == WALK_HDR0 ||
                    walk_phase == WALK_HDR1 || idx < 64'd3) begin
                    verdict = VERDICT_INVALID;
                    endpos  = '0;
                end else begin
                    verdict = walk_scan_seen ? VERDICT_PROMISING : VERDICT_INVALID;
                end
                emit = 1'b1;
            end
        end
        rec.verdict       = verdict;
        rec.stop_position = endpos[31:0];
        if (is_last) begin
            clear_walk();
        end else begin
            walk_pos = pos_add(walk_pos, 64'd1);
        end
        return emit;
    endfunction

    always @(posedge i_clk) begin : verdict_monitor
        t_verdict_rec want;
        t_verdict_rec predicted;
        if (!i_rst_n) begin
            clear_walk();
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected verdict transfer: verdict %0d stop_position %0d",
                           o_verdict, o_stop_position);
                    error_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_verdict !== want.verdict) begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, o_verdict);
                        error_count++;
                    end
                    if (o_stop_position !== want.stop_position) begin
                        $error("stop_position: expected %0d, actual %0d",
                               want.stop_position, o_stop_position);
                        error_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (walk_step(i_data_byte, i_last_byte, predicted)) begin
                    pending_verdicts.push_back(predicted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= hold_len;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++) begin
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        end
    endtask

    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    function automatic void build_walk_file();
        int         nseg;
        int         len;
        int         nscan;
        int         pick;
        logic [7:0] mark;
        file_bytes = {};
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(BYTE_SOI);
        nseg = $urandom_range(3, 0);
        for (int s = 0; s < nseg; s++) begin
            mark = 8'($urandom_range(254, 1));
            if (mark >= BYTE_RST_LO && mark <= BYTE_SOS) mark = MARK_APP0;
            pick = $urandom_range(9, 0);
            if (pick == 0) len = $urandom_range(1, 0);
            else if (pick == 1) len = $urandom_range(300, 2);
            else if (pick == 2) len = $urandom_range(65535, 301);
            else len = $urandom_range(14, 2);
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(mark);
            file_bytes.push_back(8'(len >> 8));
            file_bytes.push_back(8'(len));
            if (len > 300) begin
                // The file ends inside this segment, so the walk target lies beyond it.
                repeat ($urandom_range(6, 1)) file_bytes.push_back(8'($urandom_range(255, 0)));
                return;
            end
            for (int k = 0; k < len - 2; k++) file_bytes.push_back(8'($urandom_range(255, 0)));
        end
        if ($urandom_range(9, 0) < 7) begin
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(BYTE_SOS);
            nscan = $urandom_range(16, 0);
            for (int k = 0; k < nscan; k++) begin
                pick = $urandom_range(9, 0);
                if (pick == 0) begin
                    file_bytes.push_back(BYTE_FF);
                    file_bytes.push_back(BYTE_STUFF);
                end else if (pick == 1) begin
                    file_bytes.push_back(BYTE_FF);
                    file_bytes.push_back(BYTE_RST_LO + 8'($urandom_range(7, 0)));
                end else begin
                    file_bytes.push_back(8'($urandom_range(254, 0)));
                end
            end
        end
        pick = $urandom_range(9, 0);
        if (pick < 6) begin
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(BYTE_EOI);
            repeat ($urandom_range(2, 0)) file_bytes.push_back(8'($urandom_range(255, 0)));
        end else if (pick == 6) begin
            file_bytes.push_back(BYTE_FF);
        end else if (pick == 7) begin
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(MARK_APP1);
            file_bytes.push_back(8'($urandom_range(255, 0)));
        end
        if ($urandom_range(7, 0) == 0) begin
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1, 0)];
        end
    endfunction

    function automatic void build_noise_file();
        int n;
        file_bytes = {};
        n = $urandom_range(12, 1);
        if ($urandom_range(1, 0) == 1) begin
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(BYTE_SOI);
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9, 0) < 3) file_bytes.push_back(BYTE_FF);
            else file_bytes.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    task automatic run_random_files(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            if ($urandom_range(9, 0) < 8) build_walk_file();
            else build_noise_file();
            send_file();
        end
    endtask

    task automatic test_short_and_bad_header();
        set_idling(0, 0);
        file_bytes = '{BYTE_FF, BYTE_SOI};
        send_file();
        file_bytes = '{BYTE_FF, BYTE_STUFF, BYTE_FF, BYTE_EOI};
        send_file();
        wait_for_verdicts();
    endtask

    task automatic test_full_walk();
        set_idling(0, 0);
        file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, MARK_APP0, 8'h00, 8'h03, 8'h7F,
                       BYTE_FF, BYTE_SOS, 8'h11, BYTE_FF, BYTE_STUFF, BYTE_FF,
                       BYTE_RST_HI, BYTE_FF, BYTE_EOI, 8'h55};
        send_file();
        file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS, 8'h12, BYTE_FF};
        send_file();
        wait_for_verdicts();
    endtask

    task automatic test_short_length_and_skip_end();
        set_idling(0, 0);
        file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, MARK_DHT, 8'h00, 8'h01,
                       BYTE_FF, MARK_APP1, 8'h00, 8'h08, 8'h01};
        send_file();
        wait_for_verdicts();
    endtask

    task automatic test_random_traffic();
        set_idling(0, 0);
        run_random_files(220);
        wait_for_verdicts();
        set_idling(68, 0);
        run_random_files(220);
        wait_for_verdicts();
        set_idling(0, 68);
        run_random_files(220);
        wait_for_verdicts();
        set_idling(35, 35);
        run_random_files(220);
        wait_for_verdicts();
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_len     = 300;
        hold_trigger = hold_trigger + 1;
        repeat (30) begin
            if ($urandom_range(1, 0) == 1) begin
                file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_EOI};
            end else begin
                file_bytes = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_SOS,
                               8'($urandom_range(254, 0))};
            end
            send_file();
        end
        wait_for_verdicts();
        run_random_files(100);
        wait_for_verdicts();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_and_bad_header();
        test_full_walk();
        test_short_length_and_skip_end();
        test_random_traffic();
        test_output_backpressure();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* jpeg_marker_walk_validator.f */
rtl/jmwv_pkg.sv
rtl/jmwv_in_reg.sv
rtl/jmwv_walk.sv
rtl/jpeg_marker_walk_validator.sv
tb/jpeg_marker_walk_validator_tb.sv
